FILE: rtl/core/wsg_pkg.sv
// Shared types, constants and helpers of the five-channel wavetable sound generator.
`default_nettype none

package wsg_pkg;

    localparam int CHANNELS   = 5;
    localparam int WAVE_LEN   = 32;
    localparam int WAVE_DEPTH = 160;
    localparam int CTL_DEPTH  = 16;
    localparam int MAX_RES    = 9;
    localparam int WAVE_AW    = $clog2(WAVE_DEPTH);
    localparam int CH_AW      = $clog2(CHANNELS);
    localparam int IDX_W      = $clog2(WAVE_LEN);

    // Serial divider geometry: widest case is (cpu_clock_hz << 16) / sample_rate
    localparam int DIV_NW = 39;
    localparam int DIV_DW = 17;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Request function codes
    localparam logic [2:0] FUNC_CWR  = 3'd0;
    localparam logic [2:0] FUNC_PWR  = 3'd1;
    localparam logic [2:0] FUNC_CRD  = 3'd2;
    localparam logic [2:0] FUNC_PRD  = 3'd3;
    localparam logic [2:0] FUNC_TICK = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_RATE  = 3'd0;
    localparam logic [2:0] CFG_CLK   = 3'd1;
    localparam logic [2:0] CFG_GAIN  = 3'd2;
    localparam logic [2:0] CFG_CHIP  = 3'd3;
    localparam logic [2:0] CFG_OUTEN = 3'd4;
    localparam logic [2:0] CFG_PLUS  = 3'd5;
    localparam logic [2:0] CFG_GATE  = 3'd6;
    localparam int CFG_DW = 23;

    // Reset values
    localparam logic [16:0] RATE_RST  = 17'd44100;
    localparam logic [22:0] CLK_RST   = 23'd3579545;
    localparam logic [8:0]  GAIN_RST  = 9'd150;
    localparam logic [31:0] SCALE_RST = 32'((64'd3579545 << 16) / 64'd44100);

    // Address map
    localparam logic [7:0] ADDR_CLASSIC_LIM = 8'h80;
    localparam logic [7:0] ADDR_WAVE_LIM    = 8'hA0;
    localparam logic [7:0] ADDR_CTL_LIM     = 8'hB0;
    localparam logic [7:0] ADDR_MIRROR_LIM  = 8'hC0;
    localparam logic [7:0] ADDR_CLASSIC_TOP = 8'hE0;
    localparam logic [7:0] ADDR_PLUS_OFS    = 8'h20;
    localparam logic [7:0] ADDR_MIRROR_OFS  = 8'h10;
    localparam logic [7:0] READ_UNMAPPED    = 8'hFF;
    localparam logic [3:0] CTL_ENABLE       = 4'd15;
    localparam logic [3:0] CTL_VOL_BASE     = 4'd10;
    localparam logic [3:0] CTL_PERIOD_LAST  = 4'd9;
    localparam int         GATE_BIT         = 5;

    // Audio constants
    // Divide by 100: ceil(2^33 / 100), exact for magnitudes below 2^30
    localparam logic [26:0]        GAIN_RECIP   = 27'd85899346;
    localparam int                 GAIN_SHIFT   = 33;
    localparam logic signed [13:0] DC_COEF      = 14'sd8110;
    localparam int                 DC_SHIFT     = 13;
    localparam logic signed [31:0] SAT_HI       = 32'sd32767;
    localparam logic signed [31:0] SAT_LO       = -32'sd32768;

    localparam logic [7:0] BASE_PLUS [CHANNELS] = '{8'd0, 8'd32, 8'd64, 8'd96, 8'd128};
    localparam logic [7:0] BASE_CLASSIC_LAST    = 8'd96;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] address;
        logic [7:0] write_data;
        logic [7:0] cycles;
    } in_item_t;

    typedef struct packed {
        logic               is_read;
        logic [7:0]         read_data;
        logic signed [15:0] sample;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SWAIT,
        ST_PLO,
        ST_PHI,
        ST_PWAIT,
        ST_RD,
        ST_TCHK,
        ST_RSTART,
        ST_RCH,
        ST_RPH,
        ST_RW0,
        ST_RW1,
        ST_RACC,
        ST_GAIN,
        ST_GDIV,
        ST_GWAIT,
        ST_DC1,
        ST_DC2,
        ST_EMIT
    } wsg_state_t;

    // Start of a channel's table; classic layout shares the fourth table
    function automatic logic [7:0] wave_base(input logic [CH_AW-1:0] ch, input logic plus);
        logic [7:0] b;
        b = BASE_PLUS[ch];
        if (!plus && ch == CH_AW'(CHANNELS - 1))
        begin
            b = BASE_CLASSIC_LAST;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/wsg_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module wsg_div
    import wsg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;

    // Shift in one dividend bit, subtract when the partial remainder allows
    always_comb
    begin
        logic [DIV_DW:0] sh;
        logic            ge;
        sh        = {rem_reg, quo_reg[DIV_NW-1]};
        ge        = sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (busy_reg)
        begin
            rem_next = ge ? DIV_DW'(sh - {1'b0, dvs_reg}) : sh[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wavetable_sound_generator_5ch.sv
// Top level: register windows, sample sequencer, mixer and DC filter.
`default_nettype none

// Five-channel wavetable generator. Requests are taken one at a time. A write
// that changes a channel period has its step divided out on the shared serial
// divider (39 quotient bits) before the next request is taken. A read result
// passes through the wave RAM, the result register and the output register. A
// tick produces up to nine samples; a silent sample goes straight to output,
// otherwise each sample walks the five channels through the channel and wave
// RAMs, then passes through gain, DC filter and output. After a write of
// sample_rate or cpu_clock_hz the block takes no request while the step scale
// is recomputed. Output results wait in a register until taken.
module wavetable_sound_generator_5ch
    import wsg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_req,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_res,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_idx,
    input  wire logic [CFG_DW-1:0] cfg_wdata
);

    // Control and configuration
    wsg_state_t            state_reg, state_next;
    logic [CH_AW-1:0]      ch_reg, ch_next;
    logic [3:0]            n_reg, n_next;
    logic                  last_reg, last_next;
    logic [16:0]           rate_reg, rate_next;
    logic [22:0]           clkhz_reg, clkhz_next;
    logic [8:0]            gain_reg, gain_next;
    logic                  chip_reg, chip_next;
    logic                  outen_reg, outen_next;
    logic                  plus_reg, plus_next;
    logic                  gate_reg, gate_next;
    logic                  pend_reg, pend_next;
    logic [31:0]           scale_reg, scale_next;
    logic [31:0]           acc_reg, acc_next;
    logic [7:0]            ctl_reg [CTL_DEPTH];
    logic [7:0]            ctl_next [CTL_DEPTH];
    logic [WAVE_DEPTH-1:0] wvv_reg, wvv_next;
    logic [CHANNELS-1:0]   stv_reg, stv_next;
    logic [CHANNELS-1:0]   phv_reg, phv_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath
    logic                  wrv_reg, wrv_next;
    logic                  strv_reg, strv_next;
    logic                  phrv_reg, phrv_next;
    logic                  ff_reg, ff_next;
    logic [7:0]            plo_reg, plo_next;
    logic [31:0]           phase_reg, phase_next;
    logic [3:0]            vol_reg, vol_next;
    logic signed [8:0]     s0_reg, s0_next;
    logic signed [25:0]    prod_reg, prod_next;
    logic signed [15:0]    mix_reg, mix_next;
    logic signed [25:0]    gp_reg, gp_next;
    logic [52:0]           gq_reg, gq_next;
    logic signed [17:0]    mixq_reg, mixq_next;
    logic signed [31:0]    pin_reg, pin_next;
    logic signed [31:0]    pout_reg, pout_next;
    logic signed [45:0]    dcp_reg, dcp_next;
    out_item_t             res_reg, res_next;
    out_item_t             out_reg, out_next;

    // Memories
    logic               wv_we;
    logic [WAVE_AW-1:0] wv_waddr, wv_raddr;
    logic [7:0]         wv_wdata, wv_rdata;
    logic               st_we;
    logic [CH_AW-1:0]   st_waddr;
    logic [31:0]        st_wdata, st_rdata;
    logic               ph_we;
    logic [31:0]        ph_wdata, ph_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [3:0] ctl_idx;
    logic [7:0] ctl_rd;
    logic [4:0] mask;

    wsg_ram #(.WIDTH(8), .DEPTH(WAVE_DEPTH)) u_wave_ram (
        .clk   (clk),
        .we    (wv_we),
        .waddr (wv_waddr),
        .wdata (wv_wdata),
        .raddr (wv_raddr),
        .rdata (wv_rdata)
    );

    wsg_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_step_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (ch_reg),
        .rdata (st_rdata)
    );

    wsg_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_phase_ram (
        .clk   (clk),
        .we    (ph_we),
        .waddr (ch_reg),
        .wdata (ph_wdata),
        .raddr (ch_reg),
        .rdata (ph_rdata)
    );

    wsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Control-register read port: period bytes or channel volume (enable byte read separately)
    always_comb
    begin
        case (state_reg)
            ST_PLO:  ctl_idx = {ch_reg, 1'b0};
            ST_PHI:  ctl_idx = {ch_reg, 1'b1};
            default: ctl_idx = CTL_VOL_BASE + {1'b0, ch_reg};
        endcase
    end

    assign ctl_rd = ctl_reg[ctl_idx];
    assign mask   = ctl_reg[CTL_ENABLE][4:0];

    // Next state and datapath
    always_comb
    begin
        logic [7:0]         wa;
        logic [7:0]         pa;
        logic               pwr;
        logic [24:0]        tick_prod;
        logic [31:0]        acc_sub;
        logic [31:0]        step_v;
        logic [31:0]        ph_v;
        logic [31:0]        pn;
        logic [3:0]         vol;
        logic               adv;
        logic signed [8:0]  s1v;
        logic signed [8:0]  diff;
        logic signed [9:0]  ws;
        logic signed [14:0] wprod;
        logic [25:0]        gabs;
        logic [17:0]        q18;
        logic [11:0]        per;
        logic [12:0]        per1;
        logic signed [31:0] filt;

        wa        = in_req.address + ADDR_PLUS_OFS;
        pa        = '0;
        pwr       = 1'b0;
        tick_prod = in_req.cycles * rate_reg;
        acc_sub   = acc_reg - {9'b0, clkhz_reg};
        step_v    = strv_reg ? st_rdata : '0;
        ph_v      = phrv_reg ? ph_rdata : '0;
        pn        = ph_v + step_v;
        vol       = ctl_rd[3:0];
        adv       = 1'b0;
        s1v       = wrv_reg ? 9'($signed(wv_rdata)) : '0;
        diff      = s1v - s0_reg;
        ws        = 10'(s0_reg) + 10'(prod_reg >>> 16);
        wprod     = ws * $signed({1'b0, vol_reg});
        gabs      = gp_reg[25] ? 26'(-gp_reg) : 26'(gp_reg);
        q18       = gq_reg[GAIN_SHIFT +: 18];
        per       = {ctl_rd[3:0], plo_reg};
        per1      = {1'b0, per} + 13'd1;
        filt      = 32'(mixq_reg) - pin_reg + 32'(dcp_reg >>> DC_SHIFT);

        state_next     = state_reg;
        ch_next        = ch_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        rate_next      = rate_reg;
        clkhz_next     = clkhz_reg;
        gain_next      = gain_reg;
        chip_next      = chip_reg;
        outen_next     = outen_reg;
        plus_next      = plus_reg;
        gate_next      = gate_reg;
        pend_next      = pend_reg;
        scale_next     = scale_reg;
        acc_next       = acc_reg;
        ctl_next       = ctl_reg;
        wvv_next       = wvv_reg;
        stv_next       = stv_reg;
        phv_next       = phv_reg;
        out_valid_next = out_valid_reg;
        strv_next      = stv_reg[ch_reg];
        phrv_next      = phv_reg[ch_reg];
        ff_next        = ff_reg;
        plo_next       = plo_reg;
        phase_next     = phase_reg;
        vol_next       = vol_reg;
        s0_next        = s0_reg;
        prod_next      = prod_reg;
        mix_next       = mix_reg;
        gp_next        = gp_reg;
        gq_next        = gq_reg;
        mixq_next      = mixq_reg;
        pin_next       = pin_reg;
        pout_next      = pout_reg;
        dcp_next       = dcp_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        wv_we    = 1'b0;
        wv_waddr = in_req.address;
        wv_wdata = in_req.write_data;
        wv_raddr = in_req.address;
        st_we    = 1'b0;
        st_waddr = ch_reg;
        st_wdata = div_rsp.quotient[31:0];
        ph_we    = 1'b0;
        ph_wdata = pn;
        div_req  = '{start: 1'b0, dividend: '0, divisor: '0};
        in_ready = (state_reg == ST_IDLE) && !pend_reg;

        // Output register drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    // Step scale recompute after a rate or clock change
                    pend_next = 1'b0;
                    if (rate_reg == '0)
                    begin
                        scale_next = '0;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {clkhz_reg, 16'b0};
                        div_req.divisor  = rate_reg;
                        state_next       = ST_SWAIT;
                    end
                end
                else if (in_valid)
                begin
                    case (in_req.func)
                        FUNC_CWR:
                        begin
                            if (in_req.address < ADDR_CLASSIC_LIM)
                            begin
                                wv_we    = 1'b1;
                                wv_waddr = in_req.address;
                                wvv_next[in_req.address] = 1'b1;
                            end
                            else if (in_req.address < ADDR_CLASSIC_TOP)
                            begin
                                pwr = 1'b1;
                                pa  = wa;
                            end
                        end
                        FUNC_PWR:
                        begin
                            pwr = 1'b1;
                            pa  = in_req.address;
                        end
                        FUNC_CRD, FUNC_PRD:
                        begin
                            ff_next = in_req.address >=
                                ((in_req.func == FUNC_CRD) ? ADDR_CLASSIC_LIM : ADDR_WAVE_LIM);
                            wv_raddr   = in_req.address;
                            state_next = ST_RD;
                        end
                        FUNC_TICK:
                        begin
                            if (rate_reg != '0 && in_req.cycles != '0)
                            begin
                                acc_next   = acc_reg + 32'(tick_prod);
                                n_next     = '0;
                                state_next = ST_TCHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Plus window write
                    if (pwr)
                    begin
                        if (pa >= ADDR_CTL_LIM && pa < ADDR_MIRROR_LIM)
                        begin
                            pa = pa - ADDR_MIRROR_OFS;
                        end
                        if (pa < ADDR_WAVE_LIM)
                        begin
                            if (!(gate_reg && pa >= ADDR_CLASSIC_LIM
                                  && !ctl_reg[CTL_ENABLE][GATE_BIT]))
                            begin
                                wv_we        = 1'b1;
                                wv_waddr     = pa;
                                wvv_next[pa] = 1'b1;
                            end
                        end
                        else if (pa < ADDR_CTL_LIM)
                        begin
                            ctl_next[pa[3:0]] = in_req.write_data;
                            if (pa[3:0] <= CTL_PERIOD_LAST)
                            begin
                                ch_next    = pa[3:1];
                                state_next = ST_PLO;
                            end
                        end
                    end
                end
            end

            ST_SWAIT:
            begin
                if (div_rsp.done)
                begin
                    scale_next = (div_rsp.quotient[DIV_NW-1:32] != '0) ? '1
                                                                      : div_rsp.quotient[31:0];
                    state_next = ST_IDLE;
                end
            end

            // Frequency write: fetch period, divide the step scale
            ST_PLO:
            begin
                if (rate_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    plo_next   = ctl_rd;
                    state_next = ST_PHI;
                end
            end

            ST_PHI:
            begin
                if (per == '0)
                begin
                    st_we            = 1'b1;
                    st_wdata         = '0;
                    stv_next[ch_reg] = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {7'b0, scale_reg};
                    div_req.divisor  = {4'b0, per1};
                    state_next       = ST_PWAIT;
                end
            end

            ST_PWAIT:
            begin
                if (div_rsp.done)
                begin
                    st_we            = 1'b1;
                    stv_next[ch_reg] = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_RD:
            begin
                res_next.is_read   = 1'b1;
                res_next.read_data = ff_reg ? READ_UNMAPPED : (wrv_reg ? wv_rdata : 8'd0);
                res_next.sample    = '0;
                res_next.last      = 1'b1;
                state_next         = ST_EMIT;
            end

            // Sample loop over the rate accumulator
            ST_TCHK:
            begin
                if (n_reg < 4'(MAX_RES) && acc_reg >= {9'b0, clkhz_reg})
                begin
                    acc_next   = acc_sub;
                    last_next  = (n_reg == 4'(MAX_RES - 1)) || (acc_sub < {9'b0, clkhz_reg});
                    n_next     = n_reg + 4'd1;
                    state_next = ST_RSTART;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_RSTART:
            begin
                res_next.is_read   = 1'b0;
                res_next.read_data = '0;
                res_next.sample    = '0;
                res_next.last      = last_reg;
                if (!chip_reg || !outen_reg || mask == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ch_next    = '0;
                    mix_next   = '0;
                    state_next = ST_RCH;
                end
            end

            // Channel state read issued at ch_reg
            ST_RCH:
            begin
                state_next = ST_RPH;
            end

            ST_RPH:
            begin
                if (mask[ch_reg] && step_v != '0 && vol != '0)
                begin
                    ph_we            = 1'b1;
                    phv_next[ch_reg] = 1'b1;
                    phase_next       = pn;
                    vol_next         = vol;
                    wv_raddr         = wave_base(ch_reg, plus_reg) + {3'b0, pn[16 +: IDX_W]};
                    state_next       = ST_RW0;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            ST_RW0:
            begin
                s0_next  = wrv_reg ? 9'($signed(wv_rdata)) : '0;
                wv_raddr = wave_base(ch_reg, plus_reg)
                         + {3'b0, phase_reg[16 +: IDX_W] + IDX_W'(1)};
                state_next = ST_RW1;
            end

            ST_RW1:
            begin
                prod_next  = diff * $signed({1'b0, phase_reg[15:0]});
                state_next = ST_RACC;
            end

            ST_RACC:
            begin
                mix_next = mix_reg + 16'(wprod);
                adv      = 1'b1;
            end

            // Gain, then truncating divide by 100 on magnitude via reciprocal multiply
            ST_GAIN:
            begin
                gp_next    = mix_reg * $signed({1'b0, gain_reg});
                state_next = ST_GDIV;
            end

            ST_GDIV:
            begin
                gq_next    = gabs * GAIN_RECIP;
                state_next = ST_GWAIT;
            end

            ST_GWAIT:
            begin
                mixq_next  = gp_reg[25] ? 18'(-q18) : q18;
                state_next = ST_DC1;
            end

            // DC blocking filter
            ST_DC1:
            begin
                dcp_next   = pout_reg * DC_COEF;
                state_next = ST_DC2;
            end

            ST_DC2:
            begin
                pin_next  = 32'(mixq_reg);
                pout_next = filt;
                if (filt > SAT_HI)
                begin
                    res_next.sample = SAT_HI[15:0];
                end
                else if (filt < SAT_LO)
                begin
                    res_next.sample = SAT_LO[15:0];
                end
                else
                begin
                    res_next.sample = filt[15:0];
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = res_reg.last ? ST_IDLE : ST_TCHK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Valid mark follows the final wave read address
        wrv_next = wvv_reg[wv_raddr];

        // Next channel or mix finished
        if (adv)
        begin
            if (ch_reg == CH_AW'(CHANNELS - 1))
            begin
                state_next = ST_GAIN;
            end
            else
            begin
                ch_next    = ch_reg + 1'b1;
                state_next = ST_RCH;
            end
        end

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_RATE:
                begin
                    rate_next = cfg_wdata[16:0];
                    pend_next = 1'b1;
                end
                CFG_CLK:
                begin
                    clkhz_next = cfg_wdata[22:0];
                    pend_next  = 1'b1;
                end
                CFG_GAIN:  gain_next  = cfg_wdata[8:0];
                CFG_CHIP:  chip_next  = cfg_wdata[0];
                CFG_OUTEN: outen_next = cfg_wdata[0];
                CFG_PLUS:  plus_next  = cfg_wdata[0];
                CFG_GATE:  gate_next  = cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            n_reg         <= '0;
            last_reg      <= 1'b0;
            rate_reg      <= RATE_RST;
            clkhz_reg     <= CLK_RST;
            gain_reg      <= GAIN_RST;
            chip_reg      <= 1'b0;
            outen_reg     <= 1'b0;
            plus_reg      <= 1'b0;
            gate_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            scale_reg     <= SCALE_RST;
            acc_reg       <= '0;
            wvv_reg       <= '0;
            stv_reg       <= '0;
            phv_reg       <= '0;
            out_valid_reg <= 1'b0;
            pin_reg       <= '0;
            pout_reg      <= '0;
            for (int i = 0; i < CTL_DEPTH; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            rate_reg      <= rate_next;
            clkhz_reg     <= clkhz_next;
            gain_reg      <= gain_next;
            chip_reg      <= chip_next;
            outen_reg     <= outen_next;
            plus_reg      <= plus_next;
            gate_reg      <= gate_next;
            pend_reg      <= pend_next;
            scale_reg     <= scale_next;
            acc_reg       <= acc_next;
            wvv_reg       <= wvv_next;
            stv_reg       <= stv_next;
            phv_reg       <= phv_next;
            out_valid_reg <= out_valid_next;
            pin_reg       <= pin_next;
            pout_reg      <= pout_next;
            ctl_reg       <= ctl_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wrv_reg   <= wrv_next;
        strv_reg  <= strv_next;
        phrv_reg  <= phrv_next;
        ff_reg    <= ff_next;
        plo_reg   <= plo_next;
        phase_reg <= phase_next;
        vol_reg   <= vol_next;
        s0_reg    <= s0_next;
        prod_reg  <= prod_next;
        mix_reg   <= mix_next;
        gp_reg    <= gp_next;
        gq_reg    <= gq_next;
        mixq_reg  <= mixq_next;
        dcp_reg   <= dcp_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE && !pend_reg))
        else $error("request taken outside idle");

    a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.is_read) |-> (out_res.last && out_res.sample == '0))
        else $error("read result malformed");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_render_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RCH) |-> (chip_reg && outen_reg && mask != '0))
        else $error("channel walk on silent sample");
`endif

endmodule

`default_nettype wire
